>>> hdl/ffaa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared types and constants of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffaa_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int MAX_SEGMENTS = 256;
  localparam int ADDR_BITS = 16;
  localparam int IDX_BITS = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int LEN_BITS = 17;
  localparam int PADDR_BITS = 3;

  // Register byte addresses.
  localparam logic [PADDR_BITS-1:0] REG_ARENA_LEN = 3'd0;
  localparam logic [PADDR_BITS-1:0] REG_ENABLE = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_NOTREADY = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [15:0] size;
    logic [15:0] address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] address_res;
    logic [2:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_WAIT, S_EVAL, S_SHUP_RD, S_SHUP_WR,
    S_SHDN_RD, S_SHDN_WR, S_FINISH, S_OUT
  } state_t;

  // Datapath operations selected by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RD_CUR, OP_RD_SHUP, OP_WR_SHUP, OP_RD_SHDN,
    OP_WR_SHDN, OP_WR_NEW, OP_WR_LEN, OP_DONE
  } op_t;

  typedef struct packed {
    op_t       op;
    logic [2:0] status;
    logic      use_res;
  } cmd_t;

  typedef struct packed {
    logic       is_free;
    logic       zero_size;
    logic       last;       // current entry is the last live one
    logic       past_end;   // index reached segment count
    logic       match;      // free address matches current entry
    logic       cur_zero;   // current entry is empty
    logic       fit_reuse;
    logic       fit_new;
    logic       is_first;
    logic       full;
    logic       shup_done;
    logic       shdn_done;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/ffaa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffaa_datapath
// Segment table memory, walk index, fit checks and result register.
// ----------------------------------------------------------------------------
module ffaa_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ffaa_pkg::in_item_t       in_item,
  input  wire logic [ffaa_pkg::LEN_BITS-1:0] arena_len,
  input  wire ffaa_pkg::cmd_t           cmd,
  output ffaa_pkg::sts_t                sts,
  output ffaa_pkg::out_item_t           res
);

  localparam int IB = ffaa_pkg::IDX_BITS;
  localparam int CB = ffaa_pkg::CNT_BITS;
  localparam int AB = ffaa_pkg::ADDR_BITS;
  localparam logic [AB+2:0] HDR = (AB+3)'(ffaa_pkg::HEADER_BYTES);

  // Table: start and length packed per entry; two read ports are modeled as
  // two copies written together.
  logic [2*AB-1:0] mem_a [ffaa_pkg::MAX_SEGMENTS];
  logic [2*AB-1:0] mem_b [ffaa_pkg::MAX_SEGMENTS];
  logic [2*AB-1:0] rd_a, rd_b;

  ffaa_pkg::in_item_t item;
  logic [CB-1:0] count;
  logic [CB-1:0] idx;
  logic [CB-1:0] sh;
  logic [CB-1:0] sh_lim;
  logic [2*AB-1:0] sh_data;
  logic [AB-1:0] ns_reg;
  logic          sts_new_q;

  logic          wr_en;
  logic [IB-1:0] wr_addr;
  logic [2*AB-1:0] wr_data;
  logic [IB-1:0] ra_addr, rb_addr;

  logic [AB-1:0] cur_s, cur_l, nxt_s;
  logic [AB+2:0] gap, need, end_val, ns_w;

  assign cur_s = rd_a[2*AB-1:AB];
  assign cur_l = rd_a[AB-1:0];
  assign nxt_s = rd_b[2*AB-1:AB];
  assign ns_w = (AB+3)'(cur_s) + HDR + (AB+3)'(cur_l);
  assign gap = (AB+3)'(nxt_s) - (AB+3)'(cur_s);
  assign end_val = (arena_len > (ffaa_pkg::LEN_BITS)'(1 << AB)) ?
                   (AB+3)'(1 << AB) : (AB+3)'(arena_len);

  // Space needed for the candidate fit.
  always_comb begin
    if (cur_l != '0) begin
      need = (AB+3)'(cur_l) + HDR + HDR + (AB+3)'(item.size);
    end else begin
      need = HDR + (AB+3)'(item.size);
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.is_free = item.mode;
    sts.zero_size = (item.size == '0);
    sts.past_end = (idx >= count);
    sts.last = (idx + CB'(1) >= count);
    sts.match = ((AB+3)'(cur_s) + HDR) == (AB+3)'(item.address);
    sts.cur_zero = (cur_l == '0);
    sts.is_first = (idx == '0);
    sts.full = (count >= CB'(ffaa_pkg::MAX_SEGMENTS));
    if (idx + CB'(1) >= count) begin
      sts.fit_reuse = (cur_l == '0) &&
                      ((AB+3)'(cur_s) + HDR + (AB+3)'(item.size) <= end_val);
      sts.fit_new = (cur_l != '0) && (ns_w + HDR + (AB+3)'(item.size) <= end_val);
    end else begin
      sts.fit_reuse = (cur_l == '0) && (gap >= need);
      sts.fit_new = (cur_l != '0) && (gap >= need);
    end
    sts.shup_done = (sh <= idx + CB'(1));
    sts.shdn_done = (sh + CB'(1) >= count);
  end

  // Memory address and write selection.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[IB-1:0];
    wr_data = rd_a;
    ra_addr = idx[IB-1:0];
    rb_addr = IB'(idx + CB'(1));
    case (cmd.op)
      ffaa_pkg::OP_RD_SHUP: ra_addr = IB'(sh - CB'(1));
      ffaa_pkg::OP_WR_SHUP: begin
        wr_en = 1'b1;
        wr_addr = sh[IB-1:0];
        wr_data = rd_a;
      end
      ffaa_pkg::OP_RD_SHDN: ra_addr = IB'(sh + CB'(1));
      ffaa_pkg::OP_WR_SHDN: begin
        wr_en = 1'b1;
        wr_addr = sh[IB-1:0];
        wr_data = rd_a;
      end
      ffaa_pkg::OP_WR_NEW: begin
        wr_en = 1'b1;
        wr_addr = IB'(idx + CB'(1));
        wr_data = {ns_reg, item.size};
      end
      // A free empties the first entry; an allocation reuses it.
      ffaa_pkg::OP_WR_LEN: begin
        wr_en = 1'b1;
        wr_addr = idx[IB-1:0];
        wr_data = {sh_data[2*AB-1:AB], (item.mode ? AB'(0) : item.size)};
      end
      default: ;
    endcase
    // The first entry starts out empty at offset zero.
    if (rst) begin
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end
  end

  // Table memory with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[ra_addr];
    rd_b <= mem_b[rb_addr];
  end

  // Walk, shift and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CB'(1);
      idx <= '0;
      sh <= '0;
    end else begin
      case (cmd.op)
        ffaa_pkg::OP_LOAD: begin
          item <= in_item;
          idx <= '0;
        end
        ffaa_pkg::OP_RD_CUR: begin
          sh_data <= rd_a;
          ns_reg <= ns_w[AB-1:0];
          if (cmd.use_res) begin
            idx <= idx + CB'(1);
          end
          sh <= item.mode ? idx : count;
          sh_lim <= idx;
        end
        ffaa_pkg::OP_WR_SHUP: sh <= sh - CB'(1);
        ffaa_pkg::OP_WR_SHDN: sh <= sh + CB'(1);
        ffaa_pkg::OP_DONE: begin
          res.status <= cmd.status;
          if (!cmd.use_res || item.mode) begin
            res.address_res <= '0;
          end else if (sh_data[AB-1:0] == '0 && sh_lim == idx && !sts_new_q) begin
            res.address_res <= sh_data[2*AB-1:AB] + AB'(HDR);
          end else begin
            res.address_res <= ns_reg + AB'(HDR);
          end
        end
        default: ;
      endcase
      if (cmd.op == ffaa_pkg::OP_WR_NEW) begin
        count <= count + CB'(1);
      end
      if (cmd.op == ffaa_pkg::OP_DONE && cmd.use_res && item.mode && sh_lim != '0) begin
        count <= count - CB'(1);
      end
    end
  end

  // Remembers whether the successful allocation added an entry.
  always_ff @(posedge clk) begin
    if (rst || cmd.op == ffaa_pkg::OP_LOAD) begin
      sts_new_q <= 1'b0;
    end else if (cmd.op == ffaa_pkg::OP_WR_NEW) begin
      sts_new_q <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ffaa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffaa_ctrl
// Controller sequencing the walk, the table shifts and the result handshake.
// ----------------------------------------------------------------------------
module ffaa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire logic           enable,
  input  wire ffaa_pkg::sts_t sts,
  output ffaa_pkg::cmd_t      cmd
);

  ffaa_pkg::state_t state, state_next;
  logic [2:0] status, status_next;
  logic ok, ok_next;
  logic grow, grow_next;
  logic out_valid_q;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffaa_pkg::S_IDLE;
      status <= ffaa_pkg::ST_OK;
      ok <= 1'b0;
      grow <= 1'b0;
    end else begin
      state <= state_next;
      status <= status_next;
      ok <= ok_next;
      grow <= grow_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    status_next = status;
    ok_next = ok;
    grow_next = grow;
    cmd.op = ffaa_pkg::OP_NONE;
    cmd.status = status;
    cmd.use_res = 1'b0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ffaa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = ffaa_pkg::OP_LOAD;
          state_next = ffaa_pkg::S_CHECK;
        end
      end
      ffaa_pkg::S_CHECK: begin
        ok_next = 1'b0;
        grow_next = 1'b0;
        if (!sts.is_free && !enable) begin
          status_next = ffaa_pkg::ST_NOTREADY;
          state_next = ffaa_pkg::S_FINISH;
        end else if (!sts.is_free && sts.zero_size) begin
          status_next = ffaa_pkg::ST_ZERO;
          state_next = ffaa_pkg::S_FINISH;
        end else begin
          state_next = ffaa_pkg::S_RD;
        end
      end
      ffaa_pkg::S_RD: begin
        if (sts.past_end) begin
          status_next = sts.is_free ? ffaa_pkg::ST_UNKNOWN : ffaa_pkg::ST_NOFIT;
          state_next = ffaa_pkg::S_FINISH;
        end else begin
          state_next = ffaa_pkg::S_WAIT;
        end
      end
      ffaa_pkg::S_WAIT: state_next = ffaa_pkg::S_EVAL;
      ffaa_pkg::S_EVAL: begin
        // Latch current entry; advance index unless this entry is taken.
        cmd.op = ffaa_pkg::OP_RD_CUR;
        cmd.use_res = 1'b1;
        state_next = ffaa_pkg::S_RD;
        if (sts.is_free) begin
          if (sts.match) begin
            cmd.use_res = 1'b0;
            if (sts.is_first) begin
              status_next = sts.cur_zero ? ffaa_pkg::ST_UNKNOWN : ffaa_pkg::ST_OK;
              ok_next = !sts.cur_zero;
              state_next = sts.cur_zero ? ffaa_pkg::S_FINISH : ffaa_pkg::S_FINISH;
            end else begin
              status_next = ffaa_pkg::ST_OK;
              ok_next = 1'b1;
              state_next = ffaa_pkg::S_SHDN_RD;
            end
          end
        end else if (sts.fit_reuse) begin
          cmd.use_res = 1'b0;
          status_next = ffaa_pkg::ST_OK;
          ok_next = 1'b1;
          state_next = ffaa_pkg::S_FINISH;
        end else if (sts.fit_new) begin
          cmd.use_res = 1'b0;
          if (sts.full) begin
            status_next = ffaa_pkg::ST_FULL;
            state_next = ffaa_pkg::S_FINISH;
          end else begin
            status_next = ffaa_pkg::ST_OK;
            ok_next = 1'b1;
            grow_next = 1'b1;
            state_next = ffaa_pkg::S_SHUP_RD;
          end
        end else if (sts.last) begin
          status_next = ffaa_pkg::ST_NOFIT;
          state_next = ffaa_pkg::S_FINISH;
        end
      end
      ffaa_pkg::S_SHUP_RD: begin
        if (sts.shup_done) begin
          cmd.op = ffaa_pkg::OP_WR_NEW;
          state_next = ffaa_pkg::S_FINISH;
        end else begin
          cmd.op = ffaa_pkg::OP_RD_SHUP;
          state_next = ffaa_pkg::S_SHUP_WR;
        end
      end
      ffaa_pkg::S_SHUP_WR: begin
        cmd.op = ffaa_pkg::OP_WR_SHUP;
        state_next = ffaa_pkg::S_SHUP_RD;
      end
      ffaa_pkg::S_SHDN_RD: begin
        if (sts.shdn_done) begin
          state_next = ffaa_pkg::S_FINISH;
        end else begin
          cmd.op = ffaa_pkg::OP_RD_SHDN;
          state_next = ffaa_pkg::S_SHDN_WR;
        end
      end
      ffaa_pkg::S_SHDN_WR: begin
        cmd.op = ffaa_pkg::OP_WR_SHDN;
        state_next = ffaa_pkg::S_SHDN_RD;
      end
      ffaa_pkg::S_FINISH: begin
        // Emptying or reusing the matched entry updates its length.
        if (ok && !grow && (sts.is_free ? sts.is_first : 1'b1)) begin
          cmd.op = ffaa_pkg::OP_WR_LEN;
          state_next = ffaa_pkg::S_OUT;
          ok_next = 1'b0;
          grow_next = 1'b1;
        end else begin
          cmd.op = ffaa_pkg::OP_DONE;
          cmd.use_res = (status == ffaa_pkg::ST_OK);
          state_next = ffaa_pkg::S_OUT;
        end
      end
      ffaa_pkg::S_OUT: begin
        if (ok == 1'b0 && grow && status == ffaa_pkg::ST_OK && !out_valid_q) begin
          cmd.op = ffaa_pkg::OP_DONE;
          cmd.use_res = 1'b1;
        end
        out_valid = out_valid_q;
        if (out_valid_q && !out_stall) begin
          state_next = ffaa_pkg::S_IDLE;
        end
      end
      default: state_next = ffaa_pkg::S_IDLE;
    endcase
  end

  // Output valid is registered and raised in S_OUT; it never rises before the result is written.
  always_ff @(posedge clk) begin
    if (rst || state != ffaa_pkg::S_OUT) begin
      out_valid_q <= 1'b0;
    end else if (cmd.op == ffaa_pkg::OP_DONE || !(ok == 1'b0 && grow &&
               status == ffaa_pkg::ST_OK)) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/first_fit_arena_allocator.sv
`default_nettype none
// One item at a time: a new item is accepted only after the previous result is taken;
// the walk covers up to 256 entries in the table memory.
// Reset: synchronous active-high rst; segment count returns to one, arena_len to
// 65536, enable to 0, and table entry 0 is cleared. Other entries hold no reset value.
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// First-fit segment bookkeeping over a byte arena with an APB register port.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ffaa_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ffaa_pkg::out_item_t                      out_item,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ffaa_pkg::PADDR_BITS-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  logic [ffaa_pkg::LEN_BITS-1:0] arena_len;
  logic enable;
  ffaa_pkg::cmd_t cmd;
  ffaa_pkg::sts_t sts;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      arena_len <= ffaa_pkg::LEN_BITS'(65536);
      enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ffaa_pkg::REG_ARENA_LEN) begin
        arena_len <= pwdata[ffaa_pkg::LEN_BITS-1:0];
      end else if (paddr == ffaa_pkg::REG_ENABLE) begin
        enable <= pwdata[0];
      end
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr == ffaa_pkg::REG_ARENA_LEN) begin
      prdata = 32'(arena_len);
    end else if (paddr == ffaa_pkg::REG_ENABLE) begin
      prdata = 32'(enable);
    end
  end

  ffaa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .enable(enable),
    .sts(sts), .cmd(cmd)
  );

  ffaa_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .arena_len(arena_len),
    .cmd(cmd), .sts(sts), .res(out_item)
  );

endmodule
`default_nettype wire

>>> hdl/ffaa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffaa_checker
// Port-level checks of the allocator handshake and results.
// ----------------------------------------------------------------------------
module ffaa_port_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ffaa_pkg::out_item_t out_item
);

  // A result holds while stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // No new item is taken while a result is shown.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("item accepted while result pending");

  // Status codes stay in range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= ffaa_pkg::ST_NOTREADY)
    else $error("bad status");

  // A failing result carries a zero address.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ffaa_pkg::ST_OK |-> out_item.address_res == '0)
    else $error("address on failure");

endmodule

bind first_fit_arena_allocator ffaa_port_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

>>> verif/ffaa_checker.sv
// ----------------------------------------------------------------------------
// ffaa_checker
// Watches the item channels of the arena allocator, keeps a shadow segment
// table and compares every result against the predicted one.
// ----------------------------------------------------------------------------
module ffaa_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ffaa_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ffaa_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ffaa_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]         pwdata,
  output int                  errors,
  output int                  pending
);

  // Shadow of the block's configuration and segment table.
  logic [16:0] arena_len;
  logic        enable;
  int unsigned seg_start [ffaa_pkg::MAX_SEGMENTS];
  int unsigned seg_len [ffaa_pkg::MAX_SEGMENTS];
  int unsigned seg_count;
  ffaa_pkg::out_item_t expected_q[$];

  // Open a segment entry at table position pos.
  function automatic void insert_segment(int unsigned pos, int unsigned start,
                                         int unsigned len);
    for (int unsigned k = seg_count; k > pos; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_len[k] = seg_len[k-1];
    end
    seg_start[pos] = start;
    seg_len[pos] = len;
    seg_count++;
  endfunction

  // First-fit allocation: reuse empty first entry, fill a gap, or append.
  function automatic ffaa_pkg::out_item_t allocate(int unsigned size);
    ffaa_pkg::out_item_t r;
    int unsigned s, l, gap, ns, lim;
    r = '0;
    if (!enable) begin
      r.status = ffaa_pkg::ST_NOTREADY;
      return r;
    end
    if (size == 0) begin
      r.status = ffaa_pkg::ST_ZERO;
      return r;
    end
    lim = (arena_len > 65536) ? 65536 : arena_len;
    for (int unsigned i = 0; i < seg_count; i++) begin
      s = seg_start[i];
      l = seg_len[i];
      if (i + 1 < seg_count) begin
        gap = seg_start[i+1] - s;
        if (l != 0) begin
          if (gap >= l + 2 * ffaa_pkg::HEADER_BYTES + size) begin
            ns = s + ffaa_pkg::HEADER_BYTES + l;
            if (seg_count >= ffaa_pkg::MAX_SEGMENTS) begin
              r.status = ffaa_pkg::ST_FULL;
              return r;
            end
            insert_segment(i + 1, ns, size);
            r.address_res = 16'(ns + ffaa_pkg::HEADER_BYTES);
            r.status = ffaa_pkg::ST_OK;
            return r;
          end
        end else if (gap >= ffaa_pkg::HEADER_BYTES + size) begin
          seg_len[i] = size;
          r.address_res = 16'(s + ffaa_pkg::HEADER_BYTES);
          r.status = ffaa_pkg::ST_OK;
          return r;
        end
      end else begin
        if (l != 0) begin
          ns = s + ffaa_pkg::HEADER_BYTES + l;
          if (ns + ffaa_pkg::HEADER_BYTES + size <= lim) begin
            if (seg_count >= ffaa_pkg::MAX_SEGMENTS) begin
              r.status = ffaa_pkg::ST_FULL;
              return r;
            end
            insert_segment(i + 1, ns, size);
            r.address_res = 16'(ns + ffaa_pkg::HEADER_BYTES);
            r.status = ffaa_pkg::ST_OK;
            return r;
          end
        end else if (s + ffaa_pkg::HEADER_BYTES + size <= lim) begin
          seg_len[i] = size;
          r.address_res = 16'(s + ffaa_pkg::HEADER_BYTES);
          r.status = ffaa_pkg::ST_OK;
          return r;
        end
        r.status = ffaa_pkg::ST_NOFIT;
        return r;
      end
    end
    r.status = ffaa_pkg::ST_NOFIT;
    return r;
  endfunction

  // Free: empty the first entry or unlink any other.
  function automatic ffaa_pkg::out_item_t release_segment(int unsigned addr);
    ffaa_pkg::out_item_t r;
    r = '0;
    r.status = ffaa_pkg::ST_UNKNOWN;
    for (int unsigned i = 0; i < seg_count; i++) begin
      if (seg_start[i] + ffaa_pkg::HEADER_BYTES == addr) begin
        if (i == 0) begin
          if (seg_len[0] == 0) return r;
          seg_len[0] = 0;
        end else begin
          for (int unsigned k = i; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k] = seg_len[k+1];
          end
          seg_count--;
        end
        r.status = ffaa_pkg::ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  // Track register writes, predict on accepted items, compare results.
  always @(posedge clk) begin
    ffaa_pkg::out_item_t e;
    if (rst) begin
      arena_len <= 17'd65536;
      enable <= 1'b0;
      seg_count = 1;
      seg_start[0] = 0;
      seg_len[0] = 0;
      expected_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ffaa_pkg::REG_ARENA_LEN) arena_len <= pwdata[16:0];
        else if (paddr == ffaa_pkg::REG_ENABLE) enable <= pwdata[0];
      end
      if (in_valid && !in_stall) begin
        if (in_item.mode) expected_q.push_back(release_segment(in_item.address));
        else expected_q.push_back(allocate(in_item.size));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, got addr %0d status %0d", $time,
                   out_item.address_res, out_item.status);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_item.address_res !== e.address_res) begin
            $display("%0t: address_res expected %0d, got %0d", $time,
                     e.address_res, out_item.address_res);
            errors <= errors + 1;
          end else if (out_item.status !== e.status) begin
            $display("%0t: status expected %0d, got %0d", $time, e.status,
                     out_item.status);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end
endmodule

>>> verif/tb_first_fit_arena_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_arena_allocator
// Drives allocate and free items and register writes into the allocator
// under varied idling; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_first_fit_arena_allocator;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ffaa_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffaa_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ffaa_pkg::PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;
  logic [15:0] live_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_arena_allocator dut (.*);

  ffaa_checker checker_i (.*);

  // Generous cycle limit against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_first_fit_arena_allocator: done, errors");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  task automatic write_reg(input logic [ffaa_pkg::PADDR_BITS-1:0] a,
                           input int unsigned v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drop the input and wait until every result is in, plus some slack.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1400) @(negedge clk);
  endtask

  // Send one item; held until accepted. Valid stays up for the next item
  // unless an idle cycle or a drain follows.
  task automatic send(input logic m, input logic [15:0] sz, input logic [15:0] a);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{mode: m, size: sz, address: a};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_items(input int n);
    int unsigned k, r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 45) send(1'b0, 16'($urandom_range(1, 400)), 16'($urandom));
      else if (r < 52) send(1'b0, 16'($urandom), 16'($urandom));
      else if (r < 90 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1);
        send(1'b1, 16'($urandom), live_q[k]);
        live_q.delete(k);
      end else send(1'b1, 16'($urandom), 16'($urandom));
      // Remember returned offsets loosely: use checker-known likely addresses.
      if (in_item.mode == 1'b0) live_q.push_back(16'($urandom_range(0, 200) * 8 + 24));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    // Directed: not ready, then zero size, extremes, and the special cases.
    send(1'b0, 16'd10, 16'd0);
    send(1'b1, 16'd0, 16'd0);
    drain();
    write_reg(ffaa_pkg::REG_ENABLE, 1);
    send(1'b0, 16'd0, 16'hFFFF);
    send(1'b0, 16'hFFFF, 16'd0);
    send(1'b0, 16'd100, 16'd0);
    send(1'b0, 16'd50, 16'd0);
    send(1'b0, 16'd60, 16'd0);
    send(1'b1, 16'd0, 16'd148);
    send(1'b1, 16'd0, 16'd148);
    send(1'b0, 16'd20, 16'd0);
    send(1'b1, 16'd0, 16'd24);
    send(1'b1, 16'd0, 16'd24);
    send(1'b0, 16'd30, 16'd0);
    send(1'b0, 16'd65400, 16'd0);
    send(1'b1, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(ffaa_pkg::REG_ARENA_LEN, 240);
    send(1'b0, 16'd200, 16'd0);
    send(1'b0, 16'd1, 16'd0);
    drain();
    write_reg(ffaa_pkg::REG_ENABLE, 0);
    send(1'b1, 16'd0, 16'd24);
    drain();
    write_reg(ffaa_pkg::REG_ARENA_LEN, 32'h1FFFF);
    write_reg(ffaa_pkg::REG_ENABLE, 1);
    // Many tiny allocations to fill the table, then free every third of the first 120.
    for (int j = 0; j < 260; j++) send(1'b0, 16'd1, 16'd0);
    for (int j = 0; j < 40; j++) send(1'b1, 16'd0, 16'(24 + 25 * (3 * j + 1)));
    drain();
    write_reg(ffaa_pkg::REG_ARENA_LEN, 4000);
    send_idle = 24; recv_idle = 53;
    random_items(180);
    drain();
    write_reg(ffaa_pkg::REG_ARENA_LEN, 65536);
    send_idle = 53; recv_idle = 24;
    random_items(180);
    drain();
    write_reg(ffaa_pkg::REG_ARENA_LEN, 1000 + $urandom_range(20000));
    send_idle = 0; recv_idle = 0;
    random_items(180);
    drain();
    if (errors == 0) $display("tb_first_fit_arena_allocator: done, clean");
    else $display("tb_first_fit_arena_allocator: done, errors");
    $finish;
  end
endmodule
